// ===== src/quadrature_encoder_with_button_assert.svh =====
// assertion macros for the quadrature encoder block
`ifndef QUADRATURE_ENCODER_WITH_BUTTON_ASSERT_SVH
`define QUADRATURE_ENCODER_WITH_BUTTON_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define QENC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qenc assertion failed");
// checked on every edge, reset included
`define QENC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("qenc reset assertion failed");
`else
`define QENC_ASSERT(name, prop)
`define QENC_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== src/qenc_pkg.sv =====
// shared types, codes and the transition table of the encoder block
package qenc_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd500;

  typedef enum logic [1:0] {
    FUNC_PIN    = 2'd0,
    FUNC_BUTTON = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_POLL   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_t;

  // register word indexes
  localparam logic REG_LONG_PRESS = 1'b0;

  typedef struct packed {
    logic [1:0]  func;
    logic        pin_a;
    logic        pin_b;
    logic        edge_fall;
    logic        edge_rise;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [29:0] delta;
    logic [1:0]  button_event;
  } res_t;

  typedef struct packed {
    logic held;
    logic rotation_blocked;
    logic pos_zero;
  } status_t;

  // quadrature step for a 4-bit {old_a, old_b, new_a, new_b} history
  function automatic logic [1:0] step_of(input logic [3:0] hist);
    logic [1:0] s;
    case (hist)
      4'd1, 4'd7, 4'd8, 4'd14: s = 2'b11;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'b01;
      default: s = 2'b00;
    endcase
    return s;
  endfunction

endpackage

// ===== src/qenc_cfg.sv =====
// apb register holding the long press threshold
module qenc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qenc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [qenc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [qenc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [15:0]                      long_press_ms
);
  import qenc_pkg::*;

  logic wr_en;
  logic sel_lp;

  assign pready = 1'b1;
  assign sel_lp = (paddr[CFG_ADDR_W-1] == REG_LONG_PRESS);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
    end else if (wr_en && sel_lp) begin
      long_press_ms <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_lp) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, long_press_ms};
    end
  end

endmodule

// ===== src/qenc_core.sv =====
// decoder state and the update for one request, applied when step is high
module qenc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  qenc_pkg::req_t    req,
  input  logic [15:0]       long_press_ms,
  output qenc_pkg::res_t    res,
  output qenc_pkg::status_t status
);
  import qenc_pkg::*;

  logic [3:0]  pin_history, pin_history_next;
  logic [31:0] position, position_next;
  logic [31:0] press_start, press_start_next;
  logic        held, held_next;
  logic        reported, reported_next;
  logic        rotation_blocked, rotation_blocked_next;

  logic [1:0]  levels;
  logic [3:0]  hist_shift;
  logic [1:0]  step_val;
  logic [32:0] sum;
  logic [31:0] biased;
  logic [31:0] quot;
  logic [31:0] dur;

  assign levels     = {req.pin_a, req.pin_b};
  assign hist_shift = {pin_history[1:0], levels};
  assign step_val   = step_of(hist_shift);
  assign sum        = {position[31], position} + {{31{step_val[1]}}, step_val};
  // bias negatives by 3 so the shift truncates toward zero
  assign biased     = position + {30'd0, {2{position[31]}}};
  assign quot       = $signed(biased) >>> 2;
  assign dur        = req.now_ms - press_start;

  always_comb begin
    pin_history_next      = pin_history;
    position_next         = position;
    press_start_next      = press_start;
    held_next             = held;
    reported_next         = reported;
    rotation_blocked_next = rotation_blocked;
    res.delta             = '0;
    res.button_event      = EVT_NONE;
    case (func_t'(req.func))
      FUNC_PIN: begin
        if (!rotation_blocked) begin
          pin_history_next = hist_shift;
          if (sum[32] != sum[31]) begin
            position_next = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            position_next = sum[31:0];
          end
        end
      end
      FUNC_BUTTON: begin
        if (req.edge_fall) begin
          press_start_next      = req.now_ms;
          held_next             = 1'b1;
          reported_next         = 1'b0;
          rotation_blocked_next = 1'b1;
          position_next         = '0;
        end else if (req.edge_rise) begin
          held_next             = 1'b0;
          rotation_blocked_next = 1'b0;
          pin_history_next      = {2'b00, levels};
        end
      end
      FUNC_READ: begin
        if (held) begin
          position_next = '0;
        end else begin
          res.delta     = quot[29:0];
          position_next = position - {quot[29:0], 2'b00};
        end
      end
      FUNC_POLL: begin
        if (!held && reported) begin
          reported_next    = 1'b0;
          press_start_next = '0;
        end else if (held && !reported) begin
          if (dur > {16'd0, long_press_ms}) begin
            reported_next    = 1'b1;
            res.button_event = EVT_LONG;
          end
        end else if (!held && !reported && press_start != '0) begin
          if (dur < {16'd0, long_press_ms}) begin
            reported_next    = 1'b1;
            res.button_event = EVT_SHORT;
          end else begin
            press_start_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_history      <= '0;
      position         <= '0;
      press_start      <= '0;
      held             <= 1'b0;
      reported         <= 1'b0;
      rotation_blocked <= 1'b0;
    end else if (step) begin
      pin_history      <= pin_history_next;
      position         <= position_next;
      press_start      <= press_start_next;
      held             <= held_next;
      reported         <= reported_next;
      rotation_blocked <= rotation_blocked_next;
    end
  end

  assign status = {held, rotation_blocked, (position == '0)};

endmodule

// ===== src/quadrature_encoder_with_button.sv =====
// Quadrature encoder decoder with push-button classifier. Takes one request per
// clock while results are taken: an accepted request sits in an input register,
// where the result is computed from it and the decoder state; when the output
// register is free or draining, the decoder state is updated and the result is
// loaded into the output register at the same edge, where it can then be taken.
// Throughput is one request per cycle as long as results are taken; a stalled
// result holds one request in the input register and then stops new requests.
// The long press threshold is written over the apb port at byte address 0 and
// should only be changed while no request is in flight.
`include "quadrature_encoder_with_button_assert.svh"

module quadrature_encoder_with_button (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qenc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [qenc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [qenc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic [1:0]                       func,
  input  logic                             pin_a,
  input  logic                             pin_b,
  input  logic                             edge_fall,
  input  logic                             edge_rise,
  input  logic [31:0]                      now_ms,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic signed [29:0]               delta,
  output logic [1:0]                       button_event
);
  import qenc_pkg::*;

  logic        s1_valid;
  req_t        s1_req;
  logic        s1_fire;
  res_t        core_res;
  res_t        res_q;
  status_t     status;
  logic [15:0] long_press_ms;

  qenc_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .long_press_ms (long_press_ms)
  );

  qenc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_fire),
    .req           (s1_req),
    .long_press_ms (long_press_ms),
    .res           (core_res),
    .status        (status)
  );

  // the held request moves on when the output register is free or draining
  assign s1_fire   = s1_valid && (!res_valid || res_ready);
  assign req_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req.func      <= func;
      s1_req.pin_a     <= pin_a;
      s1_req.pin_b     <= pin_b;
      s1_req.edge_fall <= edge_fall;
      s1_req.edge_rise <= edge_rise;
      s1_req.now_ms    <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_q <= core_res;
    end
  end

  assign delta        = $signed(res_q.delta);
  assign button_event = res_q.button_event;

  `QENC_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid && !s1_valid)
  `QENC_ASSERT(a_event_no_delta, res_valid && button_event != EVT_NONE |-> delta == '0)
  `QENC_ASSERT(a_held_pos_clear, status.held |-> status.pos_zero && status.rotation_blocked)
  `QENC_ASSERT(a_stage_advance, s1_valid && (!res_valid || res_ready) |=> res_valid)

endmodule
